// ----- rtl/core/teq_pkg.sv -----
// Package for the timer event queue: sizes, command and result codes, state type.
// No dependencies.
`timescale 1ns / 1ps
package teq_pkg;
	localparam int ENTRIES   = 16;
	localparam int SLOT_BITS = $clog2(ENTRIES);
	localparam int TIME_BITS = 48;
	localparam int ID_BITS   = 32;

	typedef enum logic [1:0] {
		CMD_SCHED   = 2'd0,
		CMD_CANCEL  = 2'd1,
		CMD_ADVANCE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_FIRED  = 2'd0,
		KIND_REPORT = 2'd1,
		KIND_SACK   = 2'd2,
		KIND_CACK   = 2'd3
	} kind_t;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_IDS  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_SCAN,
		ST_DECIDE,
		ST_OUT
	} state_t;
endpackage

// ----- rtl/core/timer_event_queue.sv -----
// Timer event queue top level: slot table, command sequencer, shared scan unit.
// Depends on teq_pkg.
`timescale 1ns / 1ps
// A command beat (schedule, cancel, advance, none) is answered by an optional
// ack beat, one fired beat per expired live event, and a report beat with tlast
// set. The table is scanned one slot per cycle by one shared compare unit. A
// command is decoded and then the table is scanned in full; the ack beat, if any,
// goes out before the first decision, and each fired event and each expired
// cancelled event is followed by a new full scan. m_tready low holds off a beat.
// s_tready stays low from the accepted beat until the report beat has been taken.
module timer_event_queue import teq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [1:0]   s_tuser, // command
	// delay[47:0], elapsed[79:48], handler[87:80], user_context[151:88],
	// cancel_id[183:152]
	input  logic [183:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// event_id[31:0], fired_handler[39:32], fired_context[103:40],
	// has_pending[104], time_until_next[152:105], error[154:153], found[155]
	output logic [159:0] m_tdata,
	output logic [1:0]   m_tuser, // kind
	output logic         m_tlast
);
	localparam logic [TIME_BITS-1:0] TMAX = '1;
	localparam logic [ID_BITS-1:0]   IDMAX = '1;

	state_t state_q, state_n;
	logic [TIME_BITS-1:0] now_q;
	logic [ID_BITS-1:0]   nid_q;
	logic [ENTRIES-1:0]   used_q, live_q;
	logic [TIME_BITS-1:0] dl_q  [ENTRIES];
	logic [ID_BITS-1:0]   id_q  [ENTRIES];
	logic [7:0]           hnd_q [ENTRIES];
	logic [63:0]          ctx_q [ENTRIES];

	logic [185:0]         cmd_q;
	logic [SLOT_BITS-1:0] idx_q;
	logic                 best_v_q;
	logic [SLOT_BITS-1:0] best_q;
	logic                 ack_pend_q;
	logic [1:0]           o_kind_q, o_kind_n;
	logic [159:0]         o_data_q, o_data_n;
	logic                 o_last_q, o_last_n;

	logic [1:0]           cmd;
	logic [TIME_BITS-1:0] delay;
	logic [31:0]          elapsed;
	logic [ID_BITS-1:0]   cid;
	logic [SLOT_BITS-1:0] slot, freeslot;
	logic                 has_free;
	logic                 better;
	logic                 sched_ok;
	logic                 cancel_hit;
	logic                 expire;
	logic [TIME_BITS:0]   sum;

	assign cmd     = cmd_q[1:0];
	assign delay   = cmd_q[49:2];
	assign elapsed = cmd_q[81:50];
	assign cid     = cmd_q[185:154];
	assign slot    = idx_q;

	always_comb begin
		has_free = 1'b0;
		freeslot = '0;
		for (int i = ENTRIES-1; i >= 0; i--) begin
			if (!used_q[i]) begin
				has_free = 1'b1;
				freeslot = SLOT_BITS'(i);
			end
		end
	end

	// shared compare unit
	assign better = used_q[slot] && (!best_v_q || dl_q[slot] < dl_q[best_q] ||
		(dl_q[slot] == dl_q[best_q] && id_q[slot] < id_q[best_q]));

	assign sched_ok   = (cmd == CMD_SCHED) && (nid_q != IDMAX) && has_free;
	assign cancel_hit = (cmd == CMD_CANCEL) && ack_pend_q && used_q[slot] &&
		(id_q[slot] == cid);
	assign expire     = best_v_q && (dl_q[best_q] <= now_q);

	always_comb begin
		if (cmd == CMD_SCHED) sum = {1'b0, now_q} + {1'b0, delay};
		else sum = {1'b0, now_q} + (TIME_BITS+1)'(elapsed);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = o_data_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_n = ST_CMD;
			ST_CMD:    state_n = ST_SCAN;
			ST_SCAN:   if (idx_q == SLOT_BITS'(ENTRIES-1)) state_n = ST_DECIDE;
			ST_DECIDE: state_n = (!ack_pend_q && expire && !live_q[best_q]) ?
				ST_SCAN : ST_OUT;
			ST_OUT:    if (m_tready) state_n = o_last_q ? ST_IDLE :
				(ack_pend_q ? ST_DECIDE : ST_SCAN);
			default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		o_kind_n = o_kind_q;
		o_data_n = o_data_q;
		o_last_n = o_last_q;
		unique case (state_q)
			ST_CMD: begin
				o_data_n = '0;
				o_last_n = 1'b0;
				if (cmd == CMD_SCHED) begin
					o_kind_n = KIND_SACK;
					if (nid_q == IDMAX) o_data_n[154:153] = ERR_IDS;
					else if (!has_free) o_data_n[154:153] = ERR_FULL;
					else o_data_n[31:0] = 32'(nid_q + 1'b1);
				end else begin
					o_kind_n = KIND_CACK;
				end
			end
			ST_SCAN: if (cancel_hit && live_q[slot]) o_data_n[155] = 1'b1;
			ST_DECIDE: begin
				if (!ack_pend_q) begin
					o_data_n = '0;
					if (expire) begin
						o_kind_n         = KIND_FIRED;
						o_data_n[31:0]   = 32'(id_q[best_q]);
						o_data_n[39:32]  = hnd_q[best_q];
						o_data_n[103:40] = ctx_q[best_q];
					end else begin
						o_kind_n = KIND_REPORT;
						o_last_n = 1'b1;
						if (best_v_q) begin
							o_data_n[104]     = 1'b1;
							o_data_n[152:105] = 48'(dl_q[best_q] - now_q);
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			now_q      <= '0;
			nid_q      <= '0;
			used_q     <= '0;
			cmd_q      <= '0;
			idx_q      <= '0;
			best_v_q   <= 1'b0;
			best_q     <= '0;
			ack_pend_q <= 1'b0;
			o_kind_q   <= '0;
			o_data_q   <= '0;
			o_last_q   <= 1'b0;
		end else begin
			state_q  <= state_n;
			o_kind_q <= o_kind_n;
			o_data_q <= o_data_n;
			o_last_q <= o_last_n;
			unique case (state_q)
				ST_IDLE: if (s_tvalid) cmd_q <= {s_tdata, s_tuser};
				ST_CMD: begin
					idx_q      <= '0;
					best_v_q   <= 1'b0;
					ack_pend_q <= (cmd == CMD_SCHED) || (cmd == CMD_CANCEL);
					if (sched_ok) begin
						nid_q            <= nid_q + 1'b1;
						used_q[freeslot] <= 1'b1;
					end
					if (cmd == CMD_ADVANCE)
						now_q <= sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
				end
				ST_SCAN: begin
					if (better) begin
						best_v_q <= 1'b1;
						best_q   <= slot;
					end
					idx_q <= idx_q + 1'b1;
				end
				ST_DECIDE: begin
					if (!ack_pend_q) begin
						idx_q    <= '0;
						best_v_q <= 1'b0;
						if (expire) used_q[best_q] <= 1'b0;
					end
				end
				ST_OUT: if (m_tready) ack_pend_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// slot contents, read only for slots in use
	always_ff @(posedge clk) begin
		if (state_q == ST_CMD && sched_ok) begin
			live_q[freeslot] <= 1'b1;
			dl_q[freeslot]   <= sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
			id_q[freeslot]   <= nid_q + 1'b1;
			hnd_q[freeslot]  <= cmd_q[89:82];
			ctx_q[freeslot]  <= cmd_q[153:90];
		end
		if (state_q == ST_SCAN && cancel_hit) live_q[slot] <= 1'b0;
	end
endmodule
